// ===== rtl/core/jtl_pkg.sv =====
// Shared types, codes and keyword tables for the JSON token lexer.
// No dependencies; every other file in rtl/core uses this package.
package jtl_pkg;

  localparam int unsigned POS_WIDTH_DEF = 32;
  localparam int unsigned RES_DEPTH     = 4;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_STR  = 3'd1,
    MODE_NEG  = 3'd2,
    MODE_INT  = 3'd3,
    MODE_DOT  = 3'd4,
    MODE_FRAC = 3'd5,
    MODE_KW   = 3'd6,
    MODE_ERR  = 3'd7
  } mode_e;

  typedef enum logic [3:0] {
    KIND_STRING   = 4'd0,
    KIND_NUMBER   = 4'd1,
    KIND_NULL     = 4'd2,
    KIND_TRUE     = 4'd3,
    KIND_FALSE    = 4'd4,
    KIND_LBRACE   = 4'd5,
    KIND_RBRACE   = 4'd6,
    KIND_LBRACKET = 4'd7,
    KIND_RBRACKET = 4'd8,
    KIND_COLON    = 4'd9,
    KIND_COMMA    = 4'd10,
    KIND_END      = 4'd11,
    KIND_ERROR    = 4'd12
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_UNEXPECTED = 3'd1,
    ERR_UNTERM_STR = 3'd2,
    ERR_BARE_MINUS = 3'd3,
    ERR_BARE_DOT   = 3'd4
  } err_e;

  localparam logic [1:0] KW_NULL  = 2'd0;
  localparam logic [1:0] KW_TRUE  = 2'd1;
  localparam logic [1:0] KW_FALSE = 2'd2;

  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_N        = 8'h6E;
  localparam logic [7:0] CH_T        = 8'h74;
  localparam logic [7:0] CH_F        = 8'h66;
  localparam logic [7:0] CH_SPACE    = 8'h20;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [31:0] token_start;
    logic [31:0] token_length;
    logic [2:0]  error_code;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } step_t;

  function automatic logic [7:0] kw_char(logic [1:0] sel, logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (sel)
      KW_TRUE: begin
        case (idx)
          3'd0: ch = "t";
          3'd1: ch = "r";
          3'd2: ch = "u";
          3'd3: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      KW_FALSE: begin
        case (idx)
          3'd0: ch = "f";
          3'd1: ch = "a";
          3'd2: ch = "l";
          3'd3: ch = "s";
          3'd4: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (idx)
          3'd0: ch = "n";
          3'd1: ch = "u";
          3'd2: ch = "l";
          3'd3: ch = "l";
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] kw_len(logic [1:0] sel);
    return (sel == KW_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic kind_e kw_kind(logic [1:0] sel);
    kind_e k;
    case (sel)
      KW_TRUE:  k = KIND_TRUE;
      KW_FALSE: k = KIND_FALSE;
      default:  k = KIND_NULL;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/jtl_lexer.sv =====
// Lexer state registers and the single-pass step logic for one byte.
// Depends on jtl_pkg for modes, token kinds, error codes and keyword tables.
module jtl_lexer #(
  parameter int unsigned POS_WIDTH = jtl_pkg::POS_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  jtl_pkg::in_t  item_i,
  output jtl_pkg::step_t step_o
);

  jtl_pkg::mode_e       mode_q, mode_d;
  logic [1:0]           sel_q, sel_d;
  logic [2:0]           idx_q, idx_d;
  logic [POS_WIDTH-1:0] begin_q, begin_d;
  logic [POS_WIDTH-1:0] pos_q, pos_d;

  logic [7:0]           c;
  logic                 is_digit;
  logic                 is_space;
  logic [POS_WIDTH-1:0] pos_inc;
  logic [POS_WIDTH-1:0] span;

  logic                 idl_emit;
  jtl_pkg::res_t        idl_res;
  jtl_pkg::mode_e       idl_mode;
  logic                 idl_begin_we;
  logic [POS_WIDTH-1:0] idl_begin;
  logic                 idl_kw_we;
  logic [1:0]           idl_sel;
  logic                 idl_idx_we;

  logic [1:0]           kw_sel;
  logic [2:0]           kw_idx_inc;
  logic [2:0]           err_held;

  jtl_pkg::step_t       step;

  function automatic jtl_pkg::res_t mk_res(logic [3:0] kind, logic [POS_WIDTH-1:0] start,
                                           logic [POS_WIDTH-1:0] len, logic [2:0] code);
    jtl_pkg::res_t r;
    logic [63:0]   s64;
    logic [63:0]   l64;
    s64 = 64'(start);
    l64 = 64'(len);
    r.token_kind   = kind;
    r.token_start  = s64[31:0];
    r.token_length = l64[31:0];
    r.error_code   = code;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  assign c        = item_i.data_byte;
  assign is_digit = c inside {[8'h30:8'h39]};
  assign is_space = (c == jtl_pkg::CH_SPACE) || (c inside {[8'h09:8'h0D]});
  assign pos_inc  = (pos_q == '1) ? pos_q : pos_q + POS_WIDTH'(1);
  assign span     = pos_q - begin_q;
  assign kw_sel   = (sel_q > jtl_pkg::KW_FALSE) ? jtl_pkg::KW_NULL : sel_q;
  assign kw_idx_inc = idx_q + 3'd1;
  assign err_held = ((idx_q < 3'd1) || (idx_q > 3'd4)) ? jtl_pkg::ERR_UNEXPECTED : idx_q;

  // Between-token handling of one byte, shared by idle mode and number close.
  always_comb begin
    idl_emit     = 1'b0;
    idl_res      = '0;
    idl_mode     = jtl_pkg::MODE_IDLE;
    idl_begin_we = 1'b0;
    idl_begin    = pos_q;
    idl_kw_we    = 1'b0;
    idl_sel      = jtl_pkg::KW_NULL;
    idl_idx_we   = 1'b0;
    if (!is_space) begin
      case (c)
        jtl_pkg::CH_QUOTE: begin
          idl_begin_we = 1'b1;
          idl_begin    = pos_inc;
          idl_mode     = jtl_pkg::MODE_STR;
        end
        jtl_pkg::CH_MINUS: begin
          idl_begin_we = 1'b1;
          idl_mode     = jtl_pkg::MODE_NEG;
        end
        jtl_pkg::CH_N, jtl_pkg::CH_T, jtl_pkg::CH_F: begin
          idl_kw_we    = 1'b1;
          idl_sel      = (c == jtl_pkg::CH_N) ? jtl_pkg::KW_NULL :
                         (c == jtl_pkg::CH_T) ? jtl_pkg::KW_TRUE : jtl_pkg::KW_FALSE;
          idl_idx_we   = 1'b1;
          idl_begin_we = 1'b1;
          idl_mode     = jtl_pkg::MODE_KW;
        end
        jtl_pkg::CH_LBRACE: begin
          idl_emit = 1'b1;
          idl_res  = mk_res(jtl_pkg::KIND_LBRACE, pos_q, POS_WIDTH'(1), jtl_pkg::ERR_NONE);
        end
        jtl_pkg::CH_RBRACE: begin
          idl_emit = 1'b1;
          idl_res  = mk_res(jtl_pkg::KIND_RBRACE, pos_q, POS_WIDTH'(1), jtl_pkg::ERR_NONE);
        end
        jtl_pkg::CH_LBRACKET: begin
          idl_emit = 1'b1;
          idl_res  = mk_res(jtl_pkg::KIND_LBRACKET, pos_q, POS_WIDTH'(1), jtl_pkg::ERR_NONE);
        end
        jtl_pkg::CH_RBRACKET: begin
          idl_emit = 1'b1;
          idl_res  = mk_res(jtl_pkg::KIND_RBRACKET, pos_q, POS_WIDTH'(1), jtl_pkg::ERR_NONE);
        end
        jtl_pkg::CH_COLON: begin
          idl_emit = 1'b1;
          idl_res  = mk_res(jtl_pkg::KIND_COLON, pos_q, POS_WIDTH'(1), jtl_pkg::ERR_NONE);
        end
        jtl_pkg::CH_COMMA: begin
          idl_emit = 1'b1;
          idl_res  = mk_res(jtl_pkg::KIND_COMMA, pos_q, POS_WIDTH'(1), jtl_pkg::ERR_NONE);
        end
        default: begin
          if (is_digit) begin
            idl_begin_we = 1'b1;
            idl_mode     = jtl_pkg::MODE_INT;
          end else begin
            idl_emit   = 1'b1;
            idl_res    = mk_res(jtl_pkg::KIND_ERROR, pos_q, '0, jtl_pkg::ERR_UNEXPECTED);
            idl_idx_we = 1'b1;
            idl_mode   = jtl_pkg::MODE_ERR;
          end
        end
      endcase
    end
  end

  always_comb begin
    mode_d  = mode_q;
    sel_d   = sel_q;
    idx_d   = idx_q;
    begin_d = begin_q;
    pos_d   = pos_q;
    step    = '0;
    if (item_i.end_of_input) begin
      step.cnt = 2'd1;
      case (mode_q)
        jtl_pkg::MODE_IDLE:
          step.r0 = mk_res(jtl_pkg::KIND_END, pos_q, '0, jtl_pkg::ERR_NONE);
        jtl_pkg::MODE_STR:
          step.r0 = mk_res(jtl_pkg::KIND_ERROR, pos_q, '0, jtl_pkg::ERR_UNTERM_STR);
        jtl_pkg::MODE_NEG:
          step.r0 = mk_res(jtl_pkg::KIND_ERROR, pos_q, '0, jtl_pkg::ERR_BARE_MINUS);
        jtl_pkg::MODE_DOT:
          step.r0 = mk_res(jtl_pkg::KIND_ERROR, pos_q, '0, jtl_pkg::ERR_BARE_DOT);
        jtl_pkg::MODE_KW:
          step.r0 = mk_res(jtl_pkg::KIND_ERROR, pos_q, '0, jtl_pkg::ERR_UNEXPECTED);
        jtl_pkg::MODE_INT, jtl_pkg::MODE_FRAC: begin
          step.cnt = 2'd2;
          step.r0  = mk_res(jtl_pkg::KIND_NUMBER, begin_q, span, jtl_pkg::ERR_NONE);
          step.r1  = mk_res(jtl_pkg::KIND_END, pos_q, '0, jtl_pkg::ERR_NONE);
        end
        default:
          step.r0 = mk_res(jtl_pkg::KIND_ERROR, pos_q, '0, err_held);
      endcase
      mode_d  = jtl_pkg::MODE_IDLE;
      sel_d   = '0;
      idx_d   = '0;
      begin_d = '0;
      pos_d   = '0;
    end else begin
      pos_d = pos_inc;
      case (mode_q)
        jtl_pkg::MODE_IDLE, jtl_pkg::MODE_INT, jtl_pkg::MODE_FRAC: begin
          if (mode_q == jtl_pkg::MODE_INT && c == jtl_pkg::CH_DOT) begin
            mode_d = jtl_pkg::MODE_DOT;
          end else if (mode_q == jtl_pkg::MODE_IDLE || !is_digit) begin
            mode_d = idl_mode;
            if (idl_begin_we) begin
              begin_d = idl_begin;
            end
            if (idl_kw_we) begin
              sel_d = idl_sel;
            end
            if (idl_idx_we) begin
              idx_d = 3'd1;
            end
            if (mode_q == jtl_pkg::MODE_IDLE) begin
              step.cnt = {1'b0, idl_emit};
              step.r0  = idl_res;
            end else begin
              step.cnt = idl_emit ? 2'd2 : 2'd1;
              step.r0  = mk_res(jtl_pkg::KIND_NUMBER, begin_q, span, jtl_pkg::ERR_NONE);
              step.r1  = idl_res;
            end
          end
        end
        jtl_pkg::MODE_STR: begin
          if (c == jtl_pkg::CH_QUOTE) begin
            mode_d   = jtl_pkg::MODE_IDLE;
            step.cnt = 2'd1;
            step.r0  = mk_res(jtl_pkg::KIND_STRING, begin_q, span, jtl_pkg::ERR_NONE);
          end
        end
        jtl_pkg::MODE_NEG: begin
          if (is_digit) begin
            mode_d = jtl_pkg::MODE_INT;
          end else begin
            mode_d   = jtl_pkg::MODE_ERR;
            idx_d    = jtl_pkg::ERR_BARE_MINUS;
            step.cnt = 2'd1;
            step.r0  = mk_res(jtl_pkg::KIND_ERROR, pos_q, '0, jtl_pkg::ERR_BARE_MINUS);
          end
        end
        jtl_pkg::MODE_DOT: begin
          if (is_digit) begin
            mode_d = jtl_pkg::MODE_FRAC;
          end else begin
            mode_d   = jtl_pkg::MODE_ERR;
            idx_d    = jtl_pkg::ERR_BARE_DOT;
            step.cnt = 2'd1;
            step.r0  = mk_res(jtl_pkg::KIND_ERROR, pos_q, '0, jtl_pkg::ERR_BARE_DOT);
          end
        end
        jtl_pkg::MODE_KW: begin
          if (idx_q >= jtl_pkg::kw_len(kw_sel) || c != jtl_pkg::kw_char(kw_sel, idx_q)) begin
            mode_d   = jtl_pkg::MODE_ERR;
            idx_d    = jtl_pkg::ERR_UNEXPECTED;
            step.cnt = 2'd1;
            step.r0  = mk_res(jtl_pkg::KIND_ERROR, pos_q, '0, jtl_pkg::ERR_UNEXPECTED);
          end else begin
            idx_d = kw_idx_inc;
            if (kw_idx_inc == jtl_pkg::kw_len(kw_sel)) begin
              mode_d   = jtl_pkg::MODE_IDLE;
              step.cnt = 2'd1;
              step.r0  = mk_res(jtl_pkg::kw_kind(kw_sel), begin_q,
                                POS_WIDTH'(jtl_pkg::kw_len(kw_sel)), jtl_pkg::ERR_NONE);
            end
          end
        end
        default: begin
        end
      endcase
    end
    // mark the final result of this byte
    if (step.cnt == 2'd2) begin
      step.r1.last_of_run = 1'b1;
    end else begin
      step.r0.last_of_run = 1'b1;
    end
  end

  assign step_o = step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= jtl_pkg::MODE_IDLE;
      sel_q   <= '0;
      idx_q   <= '0;
      begin_q <= '0;
      pos_q   <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      sel_q   <= sel_d;
      idx_q   <= idx_d;
      begin_q <= begin_d;
      pos_q   <= pos_d;
    end
  end

endmodule

// ===== rtl/core/jtl_res_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per cycle while out_stall_i is low.
// Depends on jtl_pkg for the result and step types.
module jtl_res_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jtl_pkg::step_t step_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output jtl_pkg::res_t  out_data_o
);

  localparam int unsigned AW = $clog2(jtl_pkg::RES_DEPTH);
  localparam int unsigned CW = $clog2(jtl_pkg::RES_DEPTH + 1);

  jtl_pkg::res_t mem_q [jtl_pkg::RES_DEPTH];
  logic [AW-1:0] wptr_q, wptr_d;
  logic [AW-1:0] rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    n_push;
  logic          pop;
  logic [AW-1:0] wptr_nx;

  assign n_push      = push_i ? step_i.cnt : 2'd0;
  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rptr_q];
  assign room_o      = (cnt_q <= CW'(jtl_pkg::RES_DEPTH - 2));
  assign wptr_nx     = wptr_q + AW'(1);
  assign wptr_d      = wptr_q + AW'(n_push);
  assign rptr_d      = rptr_q + AW'(pop);
  assign cnt_d       = cnt_q + CW'(n_push) - CW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wptr_q] <= step_i.r0;
    end
    if (n_push == 2'd2) begin
      mem_q[wptr_nx] <= step_i.r1;
    end
  end

endmodule

// ===== rtl/core/json_token_lexer_core.sv =====
// Top level of the streaming JSON token lexer: input register, lexer, result queue.
// Depends on jtl_pkg, jtl_lexer and jtl_res_fifo.
//
// The core takes one document byte (or an end-of-input marker) per request and
// returns tokens as kind, start offset, length and error code, with last_of_run
// set on the final token a request produces. It accepts one request per cycle while
// the result queue has room; a request's tokens pass through the input register and
// then the four-entry result queue before they appear. A request can give up
// to two tokens (a number closed by the next byte, or a number closed by the end
// marker), and the core stalls its input while fewer than two queue entries are
// free, so a byte stream that yields at most one token per byte runs at one byte
// per cycle as long as the output side keeps taking them. Offsets saturate at
// 2^POS_WIDTH-1; outputs carry the low 32 bits.
module json_token_lexer_core #(
  parameter int unsigned POS_WIDTH = jtl_pkg::POS_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  jtl_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output jtl_pkg::res_t out_data_o
);

  logic           in_vld_q, in_vld_d;
  jtl_pkg::in_t   in_q;
  logic           room;
  logic           fire;
  logic           accept;
  jtl_pkg::step_t step;

  assign fire       = in_vld_q && room;
  assign in_stall_o = in_vld_q && !room;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_vld_d   = accept ? 1'b1 : (fire ? 1'b0 : in_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  jtl_lexer #(
    .POS_WIDTH(POS_WIDTH)
  ) u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .step_o (step)
  );

  jtl_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .step_i      (step),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
